### rtl/sft_pkg.sv
package sft_pkg;

	localparam int MAX_RES_DEF = 8;

	localparam int COORD_W   = 16;
	localparam int INDEX_W   = 16;
	localparam int LEVEL_W   = 4;
	localparam int RADIUS_W  = 15;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DAT_W = 15;

	// grid vector: up to 9 * 32768 in magnitude
	localparam int GRID_W = 20;
	localparam int MAG_W  = GRID_W - 1;
	localparam int L2_W   = 2 * MAG_W + 2;
	localparam int RAD_W  = L2_W + 16;
	localparam int ROOT_W = RAD_W / 2;
	localparam int DVD_W  = RADIUS_W + MAG_W + 8 + 1;
	localparam int QUO_W  = COORD_W;

	localparam logic [CFG_IDX_W-1:0] CFG_LEVEL  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_RADIUS = 2'd1;

	localparam logic [LEVEL_W-1:0]  LEVEL_RST  = 4'd8;
	localparam logic [RADIUS_W-1:0] RADIUS_RST = 15'd12288;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_LOAD,
		ST_SQ,
		ST_SQRT_GO,
		ST_SQRT_WAIT,
		ST_MUL,
		ST_DIV_GO,
		ST_DIV_WAIT,
		ST_STORE,
		ST_EMIT
	} state_t;

endpackage

### rtl/sphere_face_tessellator.sv
// Each projected vector goes through load and square (one step per component), the 28-step root,
// three multiply and divide passes and a store; a face first projects its three corners, then
// projects and emits its grid vertices in turn after the request is taken.
// One face at a time; start is taken again once busy falls.
// Each vertex is shown for one cycle with strobe high; the receiver cannot stall.
// Reset (arst_n low, asynchronous): idle, subdivision_level 8, sphere_radius 3.0.
module sphere_face_tessellator #(
	parameter int MAX_RESOLUTION = sft_pkg::MAX_RES_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [sft_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [sft_pkg::CFG_DAT_W-1:0] cfg_data,
	input  logic signed [15:0]            corner_a_x,
	input  logic signed [15:0]            corner_a_y,
	input  logic signed [15:0]            corner_a_z,
	input  logic signed [15:0]            corner_b_x,
	input  logic signed [15:0]            corner_b_y,
	input  logic signed [15:0]            corner_b_z,
	input  logic signed [15:0]            corner_c_x,
	input  logic signed [15:0]            corner_c_y,
	input  logic signed [15:0]            corner_c_z,
	input  logic [15:0]                   start_index,
	output logic                          strobe,
	output logic signed [15:0]            pos_x,
	output logic signed [15:0]            pos_y,
	output logic signed [15:0]            pos_z,
	output logic [1:0]                    tri_count,
	output logic [15:0]                   tri0_first,
	output logic [15:0]                   tri0_second,
	output logic [15:0]                   tri0_third,
	output logic [15:0]                   tri1_first,
	output logic [15:0]                   tri1_second,
	output logic [15:0]                   tri1_third,
	output logic                          last
);
	import sft_pkg::*;

	localparam logic [COORD_W-1:0] POS_MAX = 16'h7FFF;
	localparam logic [COORD_W-1:0] NEG_MIN = 16'h8000;

	state_t state_q, state_n;

	logic [LEVEL_W-1:0]  level_q;
	logic [RADIUS_W-1:0] radius_q;
	logic [RADIUS_W-1:0] r_q;
	logic [LEVEL_W-1:0]  n1_q;
	logic [LEVEL_W-1:0]  i_q;
	logic [LEVEL_W-1:0]  j_q;
	logic [1:0]          k_q;
	logic [1:0]          c_q;
	logic                grid_q;
	logic [INDEX_W-1:0]  v_q;

	logic [COORD_W-1:0] raw_q [3][3];
	logic [COORD_W-1:0] cor_q [3][3];
	logic [GRID_W-1:0]  q_q   [3];
	logic [COORD_W-1:0] p_q   [3];
	logic [L2_W-1:0]    l2_q;
	logic [ROOT_W-1:0]  m_q;
	logic [DVD_W-1:0]   num_q;

	logic               sqrt_go, sqrt_done, div_go, div_done;
	logic [ROOT_W-1:0]  root;
	logic [QUO_W-1:0]   quo;
	logic [LEVEL_W-1:0] n_clamp;
	logic               k_end, face_end;
	logic [GRID_W-1:0]  q_grid, q_k;
	logic [MAG_W-1:0]   mag_k;
	logic [COORD_W-1:0] res_k;
	logic [2*MAG_W-1:0] sq_k;
	logic [RADIUS_W+MAG_W-1:0] rm_k;

	function automatic logic [GRID_W-1:0] scale(input logic [COORD_W-1:0] c,
	                                             input logic [LEVEL_W-1:0] w);
		logic [GRID_W-1:0] cx;
		logic [GRID_W-1:0] wx;
		cx = {{(GRID_W-COORD_W){c[COORD_W-1]}}, c};
		wx = {{(GRID_W-LEVEL_W){1'b0}}, w};
		return GRID_W'(cx * wx);
	endfunction

	assign n_clamp  = (level_q > LEVEL_W'(MAX_RESOLUTION)) ? LEVEL_W'(MAX_RESOLUTION) : level_q;
	assign k_end    = k_q == 2'd2;
	assign face_end = (i_q == n1_q) && (j_q == i_q);

	// q = A*(n+1-i) + B*(i-j) + C*j, same direction as the grid point
	assign q_grid = scale(cor_q[0][k_q], n1_q - i_q) + scale(cor_q[1][k_q], i_q - j_q)
	              + scale(cor_q[2][k_q], j_q);
	assign q_k    = q_q[k_q];
	assign mag_k  = q_k[GRID_W-1] ? MAG_W'(-q_k) : q_k[MAG_W-1:0];
	assign sq_k   = {{MAG_W{1'b0}}, mag_k} * {{MAG_W{1'b0}}, mag_k};
	assign rm_k   = {{MAG_W{1'b0}}, r_q} * {{RADIUS_W{1'b0}}, mag_k};
	// clamp to the signed coordinate range
	assign res_k  = (m_q == '0) ? '0
	              : q_k[GRID_W-1] ? ((quo > NEG_MIN) ? NEG_MIN : -quo)
	              : ((quo > POS_MAX) ? POS_MAX : quo);

	sft_isqrt u_isqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.go       (sqrt_go),
		.radicand ({l2_q, 16'd0}),
		.done     (sqrt_done),
		.root     (root)
	);

	sft_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.go       (div_go),
		.dividend (num_q),
		.divisor  (m_q),
		.done     (div_done),
		.quotient (quo)
	);

	always_comb begin
		state_n = state_q;
		case (state_q)
			ST_IDLE:      if (start) state_n = ST_LOAD;
			ST_LOAD:      if (k_end) state_n = ST_SQ;
			ST_SQ:        if (k_end) state_n = ST_SQRT_GO;
			ST_SQRT_GO:   state_n = ST_SQRT_WAIT;
			ST_SQRT_WAIT: if (sqrt_done) state_n = ST_MUL;
			ST_MUL:       state_n = ST_DIV_GO;
			ST_DIV_GO:    state_n = ST_DIV_WAIT;
			ST_DIV_WAIT:  if (div_done) state_n = k_end ? ST_STORE : ST_MUL;
			ST_STORE:     state_n = (grid_q || c_q == 2'd2) ? ST_EMIT : ST_LOAD;
			ST_EMIT:      state_n = face_end ? ST_IDLE : ST_LOAD;
			default:      state_n = ST_IDLE;
		endcase
	end

	always_comb begin
		busy    = state_q != ST_IDLE;
		sqrt_go = state_q == ST_SQRT_GO;
		div_go  = state_q == ST_DIV_GO;
		strobe  = state_q == ST_EMIT;
	end

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			level_q  <= LEVEL_RST;
			radius_q <= RADIUS_RST;
			k_q      <= '0;
			c_q      <= '0;
			grid_q   <= 1'b0;
			i_q      <= '0;
			j_q      <= '0;
		end else begin
			state_q <= state_n;
			if (cfg_valid) begin
				if (cfg_index == CFG_LEVEL)
					level_q <= cfg_data[LEVEL_W-1:0];
				else if (cfg_index == CFG_RADIUS)
					radius_q <= cfg_data[RADIUS_W-1:0];
			end
			case (state_q)
				ST_IDLE: begin
					k_q    <= '0;
					c_q    <= '0;
					grid_q <= 1'b0;
					i_q    <= '0;
					j_q    <= '0;
				end
				ST_LOAD, ST_SQ: k_q <= k_end ? 2'd0 : k_q + 2'd1;
				ST_DIV_WAIT: if (div_done) k_q <= k_end ? 2'd0 : k_q + 2'd1;
				ST_STORE: if (!grid_q) begin
					if (c_q == 2'd2)
						grid_q <= 1'b1;
					else
						c_q <= c_q + 2'd1;
				end
				ST_EMIT: begin
					// advance along the row, wrap to the next one
					if (j_q == i_q) begin
						i_q <= i_q + 1'b1;
						j_q <= '0;
					end else begin
						j_q <= j_q + 1'b1;
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: if (start) begin
				raw_q[0] <= '{corner_a_x, corner_a_y, corner_a_z};
				raw_q[1] <= '{corner_b_x, corner_b_y, corner_b_z};
				raw_q[2] <= '{corner_c_x, corner_c_y, corner_c_z};
				v_q      <= start_index;
				n1_q     <= n_clamp + 1'b1;
				r_q      <= radius_q;
			end
			ST_LOAD: begin
				q_q[k_q] <= grid_q ? q_grid
				          : {{(GRID_W-COORD_W){raw_q[c_q][k_q][COORD_W-1]}}, raw_q[c_q][k_q]};
				l2_q     <= '0;
			end
			ST_SQ: l2_q <= l2_q + L2_W'(sq_k);
			ST_SQRT_WAIT: if (sqrt_done) m_q <= root;
			ST_MUL: num_q <= DVD_W'({rm_k, 8'd0}) + DVD_W'(m_q >> 1);
			ST_DIV_WAIT: if (div_done) p_q[k_q] <= res_k;
			ST_STORE: if (!grid_q) cor_q[c_q] <= p_q;
			ST_EMIT: v_q <= v_q + 1'b1;
			default: ;
		endcase
	end

	always_comb begin
		logic has_tri;
		logic two;
		has_tri = (i_q != '0) && (j_q < i_q);
		two     = has_tri && (j_q != '0);
		if (i_q == '0) begin
			pos_x = cor_q[0][0];
			pos_y = cor_q[0][1];
			pos_z = cor_q[0][2];
		end else begin
			pos_x = p_q[0];
			pos_y = p_q[1];
			pos_z = p_q[2];
		end
		tri_count   = two ? 2'd2 : (has_tri ? 2'd1 : 2'd0);
		tri0_first  = has_tri ? v_q - INDEX_W'(i_q) : '0;
		tri0_second = has_tri ? v_q : '0;
		tri0_third  = has_tri ? v_q + 1'b1 : '0;
		tri1_first  = two ? v_q - INDEX_W'(i_q) : '0;
		tri1_second = two ? v_q - INDEX_W'(i_q) - 1'b1 : '0;
		tri1_third  = two ? v_q : '0;
		last        = face_end;
	end
endmodule

### rtl/sft_isqrt.sv
module sft_isqrt (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       go,
	input  logic [sft_pkg::RAD_W-1:0]  radicand,
	output logic                       done,
	output logic [sft_pkg::ROOT_W-1:0] root
);
	import sft_pkg::*;

	localparam int CNT_W = $clog2(ROOT_W + 1);

	logic [RAD_W-1:0]    rad_q;
	logic [ROOT_W+2:0]   rem_q;
	logic [ROOT_W-1:0]   root_q;
	logic [CNT_W-1:0]    cnt_q;
	logic                busy_q;
	logic                done_q;
	logic [ROOT_W+2:0]   rem_n;
	logic [ROOT_W+2:0]   trial;
	logic                fits;

	// two radicand bits per step, one root bit out
	assign rem_n = {rem_q[ROOT_W:0], rad_q[RAD_W-1 -: 2]};
	assign trial = {1'b0, root_q, 2'b01};
	assign fits  = rem_n >= trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (go) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(ROOT_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			rad_q  <= radicand;
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			rad_q  <= {rad_q[RAD_W-3:0], 2'b00};
			rem_q  <= fits ? rem_n - trial : rem_n;
			root_q <= {root_q[ROOT_W-2:0], fits};
		end
	end

	assign done = done_q;
	assign root = root_q;
endmodule

### rtl/sft_div.sv
module sft_div (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       go,
	input  logic [sft_pkg::DVD_W-1:0]  dividend,
	input  logic [sft_pkg::ROOT_W-1:0] divisor,
	output logic                       done,
	output logic [sft_pkg::QUO_W-1:0]  quotient
);
	import sft_pkg::*;

	localparam int CNT_W = $clog2(DVD_W + 1);

	logic [DVD_W-1:0]  dvd_q;
	logic [ROOT_W-1:0] dsr_q;
	logic [ROOT_W-1:0] rem_q;
	logic [QUO_W-1:0]  quo_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              busy_q;
	logic              done_q;
	logic [ROOT_W:0]   rem_n;
	logic              fits;

	// restoring division, one dividend bit per step
	assign rem_n = {rem_q, dvd_q[DVD_W-1]};
	assign fits  = rem_n >= {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (go) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(DVD_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			dvd_q <= dividend;
			dsr_q <= divisor;
			rem_q <= '0;
			quo_q <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[DVD_W-2:0], 1'b0};
			rem_q <= fits ? ROOT_W'(rem_n - {1'b0, dsr_q}) : rem_n[ROOT_W-1:0];
			quo_q <= {quo_q[QUO_W-2:0], fits};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;
endmodule
